/* sv/crast_pkg.sv */
package crast_pkg;

    localparam int COORD_BITS_DEF = 10;
    localparam int PT_BITS        = 12;
    localparam int PT_IDX_BITS    = 3;
    localparam logic [PT_IDX_BITS-1:0] FIRST_PT_IDX = 3'd0;
    localparam logic [PT_IDX_BITS-1:0] LAST_PT_IDX  = 3'd7;

    // Decision word is six bits wider than a coordinate, offsets one bit wider
    localparam int DEC_EXTRA = 6;
    localparam int OFF_EXTRA = 1;

    localparam logic ACTION_START = 1'b0;
    localparam logic ACTION_STEP  = 1'b1;

    localparam logic MODE_MIDPOINT  = 1'b0;
    localparam logic MODE_BRESENHAM = 1'b1;
    localparam logic MODE_RESET     = MODE_BRESENHAM;

    // Hand-off from the step unit to the point emitter
    typedef struct packed {
        logic push;   // a run of eight points is produced
        logic fin;    // loop condition failed: circle finished with this run
    } run_ctrl_t;

endpackage

/* sv/circle_rasterizer_core.sv */
// Channel   Handshake            Payload
// s_        s_valid / s_ready    s_action, s_center_x, s_center_y, s_radius
// m_        m_valid / m_ready    m_point_x, m_point_y, m_last, m_done_res
// cfg_      cfg_wr_en (no wait)  cfg_wr_data: mode, 1 Bresenham / 0 midpoint
//
// A request that draws gives eight points, one per cycle while m_ready is high,
// and all of them leave through the single output register.
// The step unit updates the circle state in the cycle of acceptance; the run is then
// held for the emitter, so the next request is taken as the eighth point loads.
// A request that draws nothing (zero radius, step while idle) gives no points.
// Reset (aresetn, synchronous) clears the circle state and selects Bresenham.
// A stall on m_ready freezes the current point; s_ready drops until the run drains.
module circle_rasterizer_core
    import crast_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_wr_en,
    input  logic                        cfg_wr_data,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic                        s_action,
    input  logic [COORD_BITS-1:0]       s_center_x,
    input  logic [COORD_BITS-1:0]       s_center_y,
    input  logic [COORD_BITS-1:0]       s_radius,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic signed [PT_BITS-1:0]   m_point_x,
    output logic signed [PT_BITS-1:0]   m_point_y,
    output logic                        m_last,
    output logic                        m_done_res
);

    logic                  mode_reg;
    logic                  s_accept;
    logic                  run_ready;
    run_ctrl_t             run_ctrl;
    logic [COORD_BITS-1:0] run_origin_x, run_origin_y;
    logic [COORD_BITS:0]   run_offset_a, run_offset_b;

    // Decision rule select; the user writes it only while the core is quiet (not enforced here)
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= MODE_RESET;
        end else if (cfg_wr_en) begin
            mode_reg <= cfg_wr_data;
        end
    end

    // Take a request whenever the emitter can hold one more run
    assign s_ready  = run_ready;
    assign s_accept = s_valid && s_ready;

    // Advance the circle state and produce the run descriptor
    crast_step #(
        .COORD_BITS (COORD_BITS)
    ) u_step (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .accept       (s_accept),
        .mode         (mode_reg),
        .action       (s_action),
        .center_x     (s_center_x),
        .center_y     (s_center_y),
        .radius       (s_radius),
        .run_ctrl     (run_ctrl),
        .run_origin_x (run_origin_x),
        .run_origin_y (run_origin_y),
        .run_offset_a (run_offset_a),
        .run_offset_b (run_offset_b)
    );

    // Hold the run and send its eight mirror points through the output register
    crast_emit #(
        .COORD_BITS (COORD_BITS)
    ) u_emit (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .run_ctrl     (run_ctrl),
        .run_origin_x (run_origin_x),
        .run_origin_y (run_origin_y),
        .run_offset_a (run_offset_a),
        .run_offset_b (run_offset_b),
        .run_ready    (run_ready),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_point_x    (m_point_x),
        .m_point_y    (m_point_y),
        .m_last       (m_last),
        .m_done_res   (m_done_res)
    );

endmodule

/* sv/crast_step.sv */
module crast_step
    import crast_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        accept,
    input  logic                        mode,
    input  logic                        action,
    input  logic [COORD_BITS-1:0]       center_x,
    input  logic [COORD_BITS-1:0]       center_y,
    input  logic [COORD_BITS-1:0]       radius,
    output run_ctrl_t                   run_ctrl,
    output logic [COORD_BITS-1:0]       run_origin_x,
    output logic [COORD_BITS-1:0]       run_origin_y,
    output logic [COORD_BITS:0]         run_offset_a,
    output logic [COORD_BITS:0]         run_offset_b
);

    localparam int OFF_BITS = COORD_BITS + OFF_EXTRA;
    localparam int DEC_BITS = COORD_BITS + DEC_EXTRA;
    localparam int A_PAD    = DEC_BITS - OFF_BITS - 1;
    localparam int B_PAD    = DEC_BITS - OFF_BITS;
    localparam int R_PAD    = DEC_BITS - COORD_BITS;

    localparam logic [DEC_BITS-1:0] K_ONE   = DEC_BITS'(1);
    localparam logic [DEC_BITS-1:0] K_THREE = DEC_BITS'(3);
    localparam logic [DEC_BITS-1:0] K_SIX   = DEC_BITS'(6);
    localparam logic [DEC_BITS-1:0] K_TEN   = DEC_BITS'(10);

    logic [COORD_BITS-1:0] origin_x_reg, origin_x_next;
    logic [COORD_BITS-1:0] origin_y_reg, origin_y_next;
    logic [OFF_BITS-1:0]   offset_a_reg, offset_a_next;
    logic [OFF_BITS-1:0]   offset_b_reg, offset_b_next;
    logic [DEC_BITS-1:0]   decision_reg, decision_next;
    logic                  busy_reg, busy_next;

    logic [OFF_BITS:0]     a_inc;
    logic [OFF_BITS-1:0]   b_dec_sat;
    logic [DEC_BITS-1:0]   a_w, b_sat_w, r_w;
    logic                  dec_neg, dec_zero;
    logic                  produce;
    logic                  fin;

    assign a_inc     = {1'b0, offset_a_reg} + {{OFF_BITS{1'b0}}, 1'b1};
    assign b_dec_sat = (offset_b_reg != '0) ? offset_b_reg - OFF_BITS'(1) : offset_b_reg;
    assign a_w       = {{A_PAD{1'b0}}, a_inc};
    assign b_sat_w   = {{B_PAD{1'b0}}, b_dec_sat};
    assign r_w       = {{R_PAD{1'b0}}, radius};
    assign dec_neg   = decision_reg[DEC_BITS-1];
    assign dec_zero  = (decision_reg == '0);

    always_comb begin
        origin_x_next = origin_x_reg;
        origin_y_next = origin_y_reg;
        offset_a_next = offset_a_reg;
        offset_b_next = offset_b_reg;
        decision_next = decision_reg;
        produce       = 1'b0;
        if (accept) begin
            if (action == ACTION_START) begin
                if (radius != '0) begin
                    origin_x_next = center_x;
                    origin_y_next = center_y;
                    offset_a_next = '0;
                    offset_b_next = {1'b0, radius};
                    decision_next = (mode == MODE_BRESENHAM) ? K_THREE - (r_w << 1)
                                                             : K_ONE - r_w;
                    produce       = 1'b1;
                end
            end else if (busy_reg) begin
                offset_a_next = a_inc[OFF_BITS-1:0];
                produce       = 1'b1;
                if (mode == MODE_BRESENHAM) begin
                    if (!dec_neg && !dec_zero) begin
                        offset_b_next = b_dec_sat;
                        decision_next = decision_reg + ((a_w - b_sat_w) << 2) + K_TEN;
                    end else begin
                        decision_next = decision_reg + (a_w << 2) + K_SIX;
                    end
                end else begin
                    if (dec_neg) begin
                        decision_next = decision_reg + (a_w << 1) + K_ONE;
                    end else begin
                        offset_b_next = b_dec_sat;
                        decision_next = decision_reg + ((a_w - b_sat_w) << 1) + K_ONE;
                    end
                end
            end
        end
    end

    // Loop test on the offsets this request leaves behind
    assign fin = (mode == MODE_BRESENHAM) ? (offset_b_next < offset_a_next)
                                          : !(offset_a_next < offset_b_next);

    always_comb begin
        if (produce) begin
            busy_next = !fin;
        end else if (accept && action == ACTION_START) begin
            busy_next = 1'b0;
        end else begin
            busy_next = busy_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            origin_x_reg <= '0;
            origin_y_reg <= '0;
            offset_a_reg <= '0;
            offset_b_reg <= '0;
            decision_reg <= '0;
            busy_reg     <= 1'b0;
        end else begin
            origin_x_reg <= origin_x_next;
            origin_y_reg <= origin_y_next;
            offset_a_reg <= offset_a_next;
            offset_b_reg <= offset_b_next;
            decision_reg <= decision_next;
            busy_reg     <= busy_next;
        end
    end

    assign run_ctrl.push = produce;
    assign run_ctrl.fin  = fin;
    assign run_origin_x  = origin_x_next;
    assign run_origin_y  = origin_y_next;
    assign run_offset_a  = offset_a_next;
    assign run_offset_b  = offset_b_next;

endmodule

/* sv/crast_emit.sv */
module crast_emit
    import crast_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  run_ctrl_t                   run_ctrl,
    input  logic [COORD_BITS-1:0]       run_origin_x,
    input  logic [COORD_BITS-1:0]       run_origin_y,
    input  logic [COORD_BITS:0]         run_offset_a,
    input  logic [COORD_BITS:0]         run_offset_b,
    output logic                        run_ready,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic signed [PT_BITS-1:0]   m_point_x,
    output logic signed [PT_BITS-1:0]   m_point_y,
    output logic                        m_last,
    output logic                        m_done_res
);

    localparam int OFF_BITS = COORD_BITS + OFF_EXTRA;
    localparam int SUM_BITS = (OFF_BITS > PT_BITS) ? OFF_BITS : PT_BITS;

    logic [COORD_BITS-1:0]  org_x_reg, org_y_reg;
    logic [OFF_BITS-1:0]    off_a_reg, off_b_reg;
    logic                   fin_reg;
    logic                   run_valid_reg;
    logic [PT_IDX_BITS-1:0] idx_reg;

    logic                   out_valid_reg;
    logic [PT_BITS-1:0]     pt_x_reg, pt_y_reg;
    logic                   last_reg, done_reg;

    logic                   out_free, load_pt, run_drain;
    logic                   swap, neg_x, neg_y;
    logic [OFF_BITS-1:0]    dx, dy;
    logic [SUM_BITS-1:0]    sum_x, sum_y;

    // Point order: bit 2 swaps the offsets, bit 0 negates x, bit 1 negates y
    assign swap  = idx_reg[2];
    assign neg_x = idx_reg[0];
    assign neg_y = idx_reg[1];
    assign dx    = swap ? off_b_reg : off_a_reg;
    assign dy    = swap ? off_a_reg : off_b_reg;
    assign sum_x = neg_x ? SUM_BITS'(org_x_reg) - SUM_BITS'(dx)
                         : SUM_BITS'(org_x_reg) + SUM_BITS'(dx);
    assign sum_y = neg_y ? SUM_BITS'(org_y_reg) - SUM_BITS'(dy)
                         : SUM_BITS'(org_y_reg) + SUM_BITS'(dy);

    assign out_free  = !out_valid_reg || m_ready;
    assign load_pt   = run_valid_reg && out_free;
    assign run_drain = load_pt && (idx_reg == LAST_PT_IDX);
    assign run_ready = !run_valid_reg || run_drain;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_valid_reg <= 1'b0;
            idx_reg       <= FIRST_PT_IDX;
        end else if (run_ctrl.push) begin
            run_valid_reg <= 1'b1;
            idx_reg       <= FIRST_PT_IDX;
        end else if (load_pt) begin
            run_valid_reg <= !run_drain;
            idx_reg       <= idx_reg + PT_IDX_BITS'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (run_ctrl.push) begin
            org_x_reg <= run_origin_x;
            org_y_reg <= run_origin_y;
            off_a_reg <= run_offset_a;
            off_b_reg <= run_offset_b;
            fin_reg   <= run_ctrl.fin;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (load_pt) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_pt) begin
            pt_x_reg <= sum_x[PT_BITS-1:0];
            pt_y_reg <= sum_y[PT_BITS-1:0];
            last_reg <= (idx_reg == LAST_PT_IDX);
            done_reg <= fin_reg;
        end
    end

    assign m_valid    = out_valid_reg;
    assign m_point_x  = $signed(pt_x_reg);
    assign m_point_y  = $signed(pt_y_reg);
    assign m_last     = last_reg;
    assign m_done_res = done_reg;

    a_push_only_when_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        run_ctrl.push |-> run_ready)
        else $error("run pushed while the emitter is still busy");

    a_eighth_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        run_drain |=> out_valid_reg && last_reg)
        else $error("eighth point of a run not flagged last");

    a_inner_not_last: assert property (@(posedge aclk) disable iff (!aresetn)
        load_pt && (idx_reg != LAST_PT_IDX) |=> out_valid_reg && !last_reg)
        else $error("inner point of a run flagged last");

    a_index_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        run_valid_reg && !run_ctrl.push && !load_pt |=> $stable(idx_reg) && run_valid_reg)
        else $error("point index moved while the output stalls");

endmodule
